FILE: rtl/rnrc_pkg.sv
// ----------------------------------------------------------------------------
// Range-normalized rainbow colormap package
// Operation codes, job kinds, back-end states and the level-to-color map.
// ----------------------------------------------------------------------------
package rnrc_pkg;

  localparam int unsigned FRAC_BITS   = 16;
  localparam int unsigned LEVEL_BITS  = 8;
  localparam int unsigned KIND_BITS   = 3;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam logic [LEVEL_BITS-1:0] LEVEL_MAX = 8'd255;

  typedef enum logic [1:0] {
    OP_FIRST   = 2'd0,
    OP_MEASURE = 2'd1,
    OP_COLOR   = 2'd2,
    OP_NONE    = 2'd3
  } op_e;

  // What the back end has to do with a color job.
  typedef enum logic [KIND_BITS-1:0] {
    KIND_WHITE = 3'd0,
    KIND_ZERO  = 3'd1,
    KIND_FLAT  = 3'd2,
    KIND_FULL  = 3'd3,
    KIND_DIV   = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    BK_IDLE  = 2'd0,
    BK_DIV   = 2'd1,
    BK_ROUND = 2'd2,
    BK_EMIT  = 2'd3
  } back_state_e;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  // Blue at level 0, green at 128, red at 255; twice the distance from the midpoint.
  function automatic rgb_t color_map(input logic [LEVEL_BITS-1:0] level);
    rgb_t       c;
    logic [7:0] twice;
    twice = {level[6:0], 1'b0};
    if (level[7]) begin
      c.red   = twice;
      c.green = ~twice;
      c.blue  = 8'd0;
    end else begin
      c.red   = 8'd0;
      c.green = twice;
      c.blue  = ~twice;
    end
    return c;
  endfunction

endpackage

FILE: rtl/range_normalized_rainbow_colormap_unit.sv
// ----------------------------------------------------------------------------
// Range-normalized rainbow colormap unit
// Tracks the range of a coordinate and false-colors points from blue to red.
// ----------------------------------------------------------------------------
// Flow: a measure is held in the front-end hold register and then applied to the
// range registers. A color job passes the hold register, the job queue and the
// back end, which divides and rounds in the scaled case, to the output register.
// Throughput: one transaction per cycle for measures while no color job waits on a
// full queue; a scaled job holds the back end through the 8-step restoring divider.
// Reset: asynchronous, active low; the range resets to zero and rainbow mode on.
// ----------------------------------------------------------------------------
module range_normalized_rainbow_colormap_unit #(
  parameter int unsigned COORD_WIDTH = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // Configuration write channel: the rainbow enable bit.
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic                   cfg_rainbow_enable_i,
  // Input channel.
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [1:0]             operation_i,
  input  logic [COORD_WIDTH-1:0] coordinate_i,
  // Result channel.
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [7:0]             red_o,
  output logic [7:0]             green_o,
  output logic [7:0]             blue_o
);

  // A queued job carries its kind, the distance from the minimum and the range width.
  localparam int unsigned JOB_W = rnrc_pkg::KIND_BITS + 2 * COORD_WIDTH;

  logic                   rainbow_q, rainbow_d;
  logic                   push_valid, push_ready, pop_valid, pop_ready;
  rnrc_pkg::kind_e        push_kind;
  logic [COORD_WIDTH-1:0] push_d, push_r;
  logic [JOB_W-1:0]       push_job, pop_job;
  rnrc_pkg::kind_e        pop_kind;
  logic [COORD_WIDTH-1:0] pop_d, pop_r;

  // The register is always ready; a write takes effect on the same edge.
  assign cfg_ready_o = 1'b1;
  assign rainbow_d   = (cfg_valid_i && cfg_ready_o) ? cfg_rainbow_enable_i : rainbow_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rainbow_q <= 1'b1;
    end else begin
      rainbow_q <= rainbow_d;
    end
  end

  // The front end applies measures at once and turns each color transaction
  // into a job with its case already decided, so the back end never needs the bounds.
  rnrc_front #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .operation_i      (operation_i),
    .coordinate_i     (coordinate_i),
    .rainbow_enable_i (rainbow_q),
    .push_valid_o     (push_valid),
    .push_ready_i     (push_ready),
    .push_kind_o      (push_kind),
    .push_d_o         (push_d),
    .push_r_o         (push_r)
  );

  assign push_job = {push_kind, push_d, push_r};

  rnrc_queue #(
    .DATA_WIDTH (JOB_W)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_job),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_job)
  );

  assign pop_kind = rnrc_pkg::kind_e'(pop_job[JOB_W-1 -: rnrc_pkg::KIND_BITS]);
  assign pop_d    = pop_job[2*COORD_WIDTH-1 -: COORD_WIDTH];
  assign pop_r    = pop_job[COORD_WIDTH-1:0];

  // The back end computes the level, divides in the scaled case, and holds
  // the result in an output register while the next job waits in the queue.
  rnrc_back #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_kind_i  (pop_kind),
    .pop_d_i     (pop_d),
    .pop_r_i     (pop_r),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .red_o       (red_o),
    .green_o     (green_o),
    .blue_o      (blue_o)
  );

  // The input side stalls only when a color job cannot enter a full queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (push_valid && !push_ready))
    else $error("input stalled while the queue had room");

  // Once the back end takes a job it is busy for at least the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_valid && pop_ready) |=> !pop_ready)
    else $error("back end took two jobs in consecutive cycles");

  // A color result is white, or has no red or no blue.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (red_o == 8'd0 || blue_o == 8'd0
                     || (red_o == 8'hFF && green_o == 8'hFF && blue_o == 8'hFF)))
    else $error("color result outside the blue-green-red map");

endmodule

FILE: rtl/rnrc_front.sv
// ----------------------------------------------------------------------------
// Range-normalized rainbow colormap front end
// Takes input transactions, keeps the measured range and classifies color jobs.
// ----------------------------------------------------------------------------
module rnrc_front #(
  parameter int unsigned COORD_WIDTH = 32
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [1:0]                 operation_i,
  input  logic [COORD_WIDTH-1:0]     coordinate_i,
  input  logic                       rainbow_enable_i,
  output logic                       push_valid_o,
  input  logic                       push_ready_i,
  output rnrc_pkg::kind_e            push_kind_o,
  output logic [COORD_WIDTH-1:0]     push_d_o,
  output logic [COORD_WIDTH-1:0]     push_r_o
);

  // Range bounds are kept as offset-binary keys so that unsigned compares order them.
  localparam logic [COORD_WIDTH-1:0] KEY_OF_ZERO = {1'b1, {(COORD_WIDTH-1){1'b0}}};

  logic                   hold_valid_q, hold_valid_d;
  logic [1:0]             hold_op_q;
  logic [COORD_WIDTH-1:0] hold_x_q;
  logic [COORD_WIDTH-1:0] kmin_q, kmin_d, kmax_q, kmax_d;
  logic [COORD_WIDTH-1:0] kx;
  logic                   is_color, done, accept;

  assign kx       = {~hold_x_q[COORD_WIDTH-1], hold_x_q[COORD_WIDTH-2:0]};
  assign is_color = (rnrc_pkg::op_e'(hold_op_q) == rnrc_pkg::OP_COLOR);
  assign done     = hold_valid_q && (!is_color || push_ready_i);
  assign in_ready_o   = !hold_valid_q || done;
  assign accept       = in_valid_i && in_ready_o;
  assign push_valid_o = hold_valid_q && is_color;

  assign push_d_o = kx - kmin_q;
  assign push_r_o = kmax_q - kmin_q;

  always_comb begin
    if (!rainbow_enable_i) begin
      push_kind_o = rnrc_pkg::KIND_WHITE;
    end else if (kx <= kmin_q) begin
      push_kind_o = rnrc_pkg::KIND_ZERO;
    end else if (kmax_q == kmin_q) begin
      push_kind_o = rnrc_pkg::KIND_FLAT;
    end else if (kx >= kmax_q) begin
      push_kind_o = rnrc_pkg::KIND_FULL;
    end else begin
      push_kind_o = rnrc_pkg::KIND_DIV;
    end
  end

  always_comb begin
    kmin_d = kmin_q;
    kmax_d = kmax_q;
    if (hold_valid_q) begin
      case (rnrc_pkg::op_e'(hold_op_q))
        rnrc_pkg::OP_FIRST: begin
          kmin_d = kx;
          kmax_d = kx;
        end
        rnrc_pkg::OP_MEASURE: begin
          if (kx < kmin_q) kmin_d = kx;
          if (kx > kmax_q) kmax_d = kx;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    if (accept) begin
      hold_valid_d = 1'b1;
    end else if (done) begin
      hold_valid_d = 1'b0;
    end else begin
      hold_valid_d = hold_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_valid_q <= 1'b0;
      kmin_q       <= KEY_OF_ZERO;
      kmax_q       <= KEY_OF_ZERO;
    end else begin
      hold_valid_q <= hold_valid_d;
      kmin_q       <= kmin_d;
      kmax_q       <= kmax_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      hold_op_q <= operation_i;
      hold_x_q  <= coordinate_i;
    end
  end

endmodule

FILE: rtl/rnrc_queue.sv
// ----------------------------------------------------------------------------
// Range-normalized rainbow colormap job queue
// Two-entry FIFO that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module rnrc_queue #(
  parameter int unsigned DATA_WIDTH = 67
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_valid_i,
  output logic                  push_ready_o,
  input  logic [DATA_WIDTH-1:0] push_data_i,
  output logic                  pop_valid_o,
  input  logic                  pop_ready_i,
  output logic [DATA_WIDTH-1:0] pop_data_o
);

  localparam int unsigned PTR_BITS = $clog2(rnrc_pkg::QUEUE_DEPTH);
  localparam int unsigned CNT_BITS = $clog2(rnrc_pkg::QUEUE_DEPTH + 1);

  logic [DATA_WIDTH-1:0] slot_q [rnrc_pkg::QUEUE_DEPTH];
  logic [PTR_BITS-1:0]   wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_BITS-1:0]   count_q, count_d;
  logic                  do_push, do_pop;

  assign push_ready_o = (count_q != CNT_BITS'(rnrc_pkg::QUEUE_DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;
  assign pop_data_o   = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_BITS'(rnrc_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_BITS'(rnrc_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

FILE: rtl/rnrc_back.sv
// ----------------------------------------------------------------------------
// Range-normalized rainbow colormap back end
// Works out the color level, with a restoring divider for the scaled case.
// ----------------------------------------------------------------------------
module rnrc_back #(
  parameter int unsigned COORD_WIDTH = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   pop_valid_i,
  output logic                   pop_ready_o,
  input  rnrc_pkg::kind_e        pop_kind_i,
  input  logic [COORD_WIDTH-1:0] pop_d_i,
  input  logic [COORD_WIDTH-1:0] pop_r_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [7:0]             red_o,
  output logic [7:0]             green_o,
  output logic [7:0]             blue_o
);

  localparam int unsigned LB      = rnrc_pkg::LEVEL_BITS;
  localparam int unsigned DW      = COORD_WIDTH + LB;
  localparam int unsigned FLAT_W  = COORD_WIDTH + rnrc_pkg::FRAC_BITS;
  localparam int unsigned CNT_W   = $clog2(LB);

  rnrc_pkg::back_state_e state_q, state_d;

  logic [DW-1:0]          rem_q, rem_d, div_q, div_d;
  logic [COORD_WIDTH-1:0] r_q, r_d;
  logic [LB-1:0]          quot_q, quot_d, level_q, level_d;
  logic [CNT_W-1:0]       cnt_q, cnt_d;
  logic                   white_q, white_d;
  logic                   out_valid_q, out_valid_d;
  rnrc_pkg::rgb_t         rgb_q, rgb_d;

  logic                   take_job, div_step, round_step, emit, out_free;
  logic [DW-1:0]          n_init, r_ext;
  logic [FLAT_W-1:0]      flat_ext, flat_sum;
  logic [LB-1:0]          flat_level;
  logic                   round_up;

  assign out_free = !out_valid_q || out_ready_i;

  // 255*d as (d << 8) - d.
  assign n_init = {pop_d_i, {LB{1'b0}}} - {{LB{1'b0}}, pop_d_i};
  assign r_ext  = {{LB{1'b0}}, r_q};

  assign round_up = (rem_q >= (r_ext - rem_q));

  // Scale of one: round the Q16.16 distance to an integer and saturate.
  assign flat_ext   = {{rnrc_pkg::FRAC_BITS{1'b0}}, pop_d_i};
  assign flat_sum   = (flat_ext >> rnrc_pkg::FRAC_BITS)
                    + FLAT_W'(flat_ext[rnrc_pkg::FRAC_BITS-1]);
  assign flat_level = (flat_sum > FLAT_W'(rnrc_pkg::LEVEL_MAX)) ? rnrc_pkg::LEVEL_MAX
                                                                : flat_sum[LB-1:0];

  always_comb begin
    state_d = state_q;
    case (state_q)
      rnrc_pkg::BK_IDLE: begin
        if (pop_valid_i) begin
          state_d = (pop_kind_i == rnrc_pkg::KIND_DIV) ? rnrc_pkg::BK_DIV : rnrc_pkg::BK_EMIT;
        end
      end
      rnrc_pkg::BK_DIV: begin
        if (cnt_q == '0) state_d = rnrc_pkg::BK_ROUND;
      end
      rnrc_pkg::BK_ROUND: begin
        state_d = rnrc_pkg::BK_EMIT;
      end
      rnrc_pkg::BK_EMIT: begin
        if (out_free) state_d = rnrc_pkg::BK_IDLE;
      end
      default: begin
        state_d = rnrc_pkg::BK_IDLE;
      end
    endcase
  end

  always_comb begin
    pop_ready_o = (state_q == rnrc_pkg::BK_IDLE);
    take_job    = pop_ready_o && pop_valid_i;
    div_step    = (state_q == rnrc_pkg::BK_DIV);
    round_step  = (state_q == rnrc_pkg::BK_ROUND);
    emit        = (state_q == rnrc_pkg::BK_EMIT) && out_free;
  end

  always_comb begin
    rem_d   = rem_q;
    div_d   = div_q;
    r_d     = r_q;
    quot_d  = quot_q;
    cnt_d   = cnt_q;
    level_d = level_q;
    white_d = white_q;
    if (take_job) begin
      white_d = (pop_kind_i == rnrc_pkg::KIND_WHITE);
      r_d     = pop_r_i;
      rem_d   = n_init;
      div_d   = {1'b0, pop_r_i, {(LB-1){1'b0}}};
      quot_d  = '0;
      cnt_d   = CNT_W'(LB - 1);
      case (pop_kind_i)
        rnrc_pkg::KIND_ZERO: level_d = '0;
        rnrc_pkg::KIND_FULL: level_d = rnrc_pkg::LEVEL_MAX;
        rnrc_pkg::KIND_FLAT: level_d = flat_level;
        default:             level_d = level_q;
      endcase
    end
    if (div_step) begin
      if (rem_q >= div_q) begin
        rem_d  = rem_q - div_q;
        quot_d = {quot_q[LB-2:0], 1'b1};
      end else begin
        quot_d = {quot_q[LB-2:0], 1'b0};
      end
      div_d = div_q >> 1;
      cnt_d = cnt_q - 1'b1;
    end
    if (round_step) begin
      level_d = quot_q + LB'(round_up);
    end
  end

  always_comb begin
    rgb_d = rgb_q;
    if (emit) begin
      out_valid_d = 1'b1;
      rgb_d = white_q ? '1 : rnrc_pkg::color_map(level_q);
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rnrc_pkg::BK_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q   <= rem_d;
    div_q   <= div_d;
    r_q     <= r_d;
    quot_q  <= quot_d;
    cnt_q   <= cnt_d;
    level_q <= level_d;
    white_q <= white_d;
    rgb_q   <= rgb_d;
  end

  assign out_valid_o = out_valid_q;
  assign red_o       = rgb_q.red;
  assign green_o     = rgb_q.green;
  assign blue_o      = rgb_q.blue;

endmodule
